// File: design/pcbd_pkg.sv
// Shared constants, types and the coefficient function of the Bezier distance block.
package pcbd_pkg;

   localparam int CoordWidth = 24;
   localparam int DistWidth = 24;
   localparam int SegmentsDefault = 25;
   localparam int SegmentsMax = 64;
   localparam int TBits = 16;
   localparam int SampleLatency = 7;
   localparam int ReqBytes = (10 * CoordWidth + 7) / 8;
   localparam int ReqDataWidth = ReqBytes * 8;
   localparam int RspDataWidth = ((DistWidth + 7) / 8) * 8;

   // Curve coordinates after sampling stay within the convex hull of the inputs.
   typedef logic signed [CoordWidth-1:0] coord_type;

   typedef struct packed {
      coord_type qx;
      coord_type qy;
      coord_type p0x;
      coord_type p0y;
      coord_type p1x;
      coord_type p1y;
      coord_type p2x;
      coord_type p2y;
      coord_type p3x;
      coord_type p3y;
   } curve_type;

   // Bernstein weight k (0..3) for sample i of n, unscaled integer.
   function automatic logic [19:0] bern_coef(input int k, input int i, input int n);
      int u;
      int r;
      begin
         u = n - i;
         unique case (k)
            0: r = u * u * u;
            1: r = 3 * i * u * u;
            2: r = 3 * i * i * u;
            default: r = i * i * i;
         endcase
         bern_coef = r[19:0];
      end
   endfunction

endpackage

// File: design/point_to_cubic_bezier_distance.sv
// Top level of the point to cubic Bezier distance block.
// One word carries a query point and four control points, all signed Q16.8.
// The curve is sampled at SEGMENTS+1 points, the squared distance from the
// query point to each of the SEGMENTS polyline segments is found by a deep
// pipelined segment unit, the minimum is kept, and a pipelined square root
// gives the distance in unsigned Q16.8, saturated at 24 bits. The sampler
// feeds one vertex per cycle while the pipeline advances, and a new word is
// taken as the last vertex of the current word is issued. Words keep their
// order; a stall on the result side freezes the whole pipeline with nothing
// lost.
module point_to_cubic_bezier_distance #(
   parameter int Segments = pcbd_pkg::SegmentsDefault
) (
   input  logic clock,
   input  logic reset,
   // query_x, query_y, start_x, start_y, ctrl_a_x, ctrl_a_y, ctrl_b_x,
   // ctrl_b_y, end_x, end_y, 24 bits each from the lowest bit up.
   input  logic [pcbd_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic req_tvalid,
   output logic req_tready,
   // distance, 24 bits.
   output logic [pcbd_pkg::RspDataWidth-1:0] rsp_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready
);
   localparam int N = (Segments < 1) ? 1 : ((Segments > 64) ? 64 : Segments);
   localparam int SL = pcbd_pkg::SampleLatency;

   // The pipeline advances whenever the output register is free or taken.
   logic adv;
   assign adv = !rsp_tvalid || rsp_tready;

   // Sequencer: holds the current curve and walks the sample index 0..N.
   pcbd_pkg::curve_type cur_ff;
   logic       busy_ff;
   logic [6:0] idx_ff;
   assign req_tready = adv && (!busy_ff || idx_ff == 7'(N));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff <= '0;
      end else if (adv) begin
         if (req_tvalid && req_tready) begin
            busy_ff <= 1'b1;
            idx_ff <= '0;
         end else if (busy_ff && idx_ff == 7'(N)) begin
            busy_ff <= 1'b0;
         end else if (busy_ff) begin
            idx_ff <= idx_ff + 7'd1;
         end
      end
      if (req_tvalid && req_tready) begin
         cur_ff.qx <= req_tdata[23:0];    cur_ff.qy <= req_tdata[47:24];
         cur_ff.p0x <= req_tdata[71:48];  cur_ff.p0y <= req_tdata[95:72];
         cur_ff.p1x <= req_tdata[119:96]; cur_ff.p1y <= req_tdata[143:120];
         cur_ff.p2x <= req_tdata[167:144]; cur_ff.p2y <= req_tdata[191:168];
         cur_ff.p3x <= req_tdata[215:192]; cur_ff.p3y <= req_tdata[239:216];
      end
   end

   // Query point and last-vertex flag travel beside the sampler.
   pcbd_pkg::coord_type qx_ff [1:SL];
   pcbd_pkg::coord_type qy_ff [1:SL];
   logic last_ff [1:SL];
   always_ff @(posedge clock) begin
      if (adv) begin
         qx_ff[1] <= cur_ff.qx;
         qy_ff[1] <= cur_ff.qy;
         last_ff[1] <= (idx_ff == 7'(N));
         for (int k = 2; k <= SL; k++) begin
            qx_ff[k] <= qx_ff[k-1];
            qy_ff[k] <= qy_ff[k-1];
            last_ff[k] <= last_ff[k-1];
         end
      end
   end

   logic s_valid, s_first;
   pcbd_pkg::coord_type s_x, s_y;
   pcbd_sample #(.Segments(Segments)) u_sample (
      .clock(clock), .reset(reset), .adv(adv),
      .curve(cur_ff), .index(idx_ff), .in_valid(busy_ff), .in_first(idx_ff == 7'd0),
      .out_valid(s_valid), .out_first(s_first), .out_x(s_x), .out_y(s_y)
   );

   // Previous vertex register forms a segment.
   pcbd_pkg::coord_type prev_x_ff, prev_y_ff;
   always_ff @(posedge clock) begin
      if (adv && s_valid) begin
         prev_x_ff <= s_x;
         prev_y_ff <= s_y;
      end
   end

   logic d_valid, d_last;
   logic [50:0] d_d2;
   pcbd_segdist u_segdist (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s_valid && !s_first), .in_last(last_ff[SL]),
      .ox(qx_ff[SL]), .oy(qy_ff[SL]), .ax(prev_x_ff), .ay(prev_y_ff), .bx(s_x), .by(s_y),
      .out_valid(d_valid), .out_last(d_last), .out_d2(d_d2)
   );

   // Running minimum; a fresh run starts after each last segment.
   logic [50:0] best_ff;
   logic        fresh_ff;
   logic [50:0] best_now;
   logic        m_valid_ff;
   logic [50:0] m_ff;
   assign best_now = (fresh_ff || d_d2 < best_ff) ? d_d2 : best_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff <= 1'b1;
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= d_valid && d_last;
         if (d_valid) fresh_ff <= d_last;
      end
      if (adv) begin
         if (d_valid) best_ff <= best_now;
         m_ff <= best_now;
      end
   end

   logic r_valid;
   logic [pcbd_pkg::DistWidth-1:0] r_root;
   pcbd_sqrt u_sqrt (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(m_valid_ff), .in_v(m_ff), .out_valid(r_valid), .out_root(r_root)
   );

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (adv) rsp_tvalid <= r_valid;
      if (adv) rsp_tdata <= pcbd_pkg::RspDataWidth'(r_root);
   end
endmodule

// File: design/pcbd_sample.sv
// Curve sampler: one polyline vertex per cycle while adv is high, through a seven-stage pipeline.
module pcbd_sample #(
   parameter int Segments = pcbd_pkg::SegmentsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  pcbd_pkg::curve_type curve,
   input  logic [6:0]         index,
   input  logic               in_valid,
   input  logic               in_first,
   output logic               out_valid,
   output logic               out_first,
   output pcbd_pkg::coord_type out_x,
   output pcbd_pkg::coord_type out_y
);
   localparam int N = (Segments < 1) ? 1 : ((Segments > 64) ? 64 : Segments);
   localparam longint Den = longint'(N) * N * N;
   localparam int CW = pcbd_pkg::CoordWidth;

   logic [19:0] coef_rom [0:3][0:64];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i <= 64; i++) begin
            coef_rom[k][i] = pcbd_pkg::bern_coef(k, i, N);
         end
      end
   end

   // Stage 1: products.
   logic signed [44:0] px_ff [0:3];
   logic signed [44:0] py_ff [0:3];
   logic               v1_ff, f1_ff;
   logic signed [CW-1:0] cx [0:3];
   logic signed [CW-1:0] cy [0:3];
   assign cx[0] = curve.p0x; assign cx[1] = curve.p1x;
   assign cx[2] = curve.p2x; assign cx[3] = curve.p3x;
   assign cy[0] = curve.p0y; assign cy[1] = curve.p1y;
   assign cy[2] = curve.p2y; assign cy[3] = curve.p3y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
      end
      if (adv) begin
         f1_ff <= in_first;
         for (int k = 0; k < 4; k++) begin
            px_ff[k] <= 45'(cx[k] * $signed({1'b0, coef_rom[k][index]}));
            py_ff[k] <= 45'(cy[k] * $signed({1'b0, coef_rom[k][index]}));
         end
      end
   end

   // Stage 2: sums, rounding numerator 2*num + den; entry 0 is x, entry 1 is y.
   logic signed [48:0] s_ff [0:1];
   logic               v2_ff, f2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= v1_ff;
      end
      if (adv) begin
         f2_ff <= f1_ff;
         s_ff[0] <= 49'(2 * (49'(px_ff[0]) + px_ff[1] + px_ff[2] + px_ff[3]) + 49'(Den));
         s_ff[1] <= 49'(2 * (49'(py_ff[0]) + py_ff[1] + py_ff[2] + py_ff[3]) + 49'(Den));
      end
   end

   // The floor divide by 2*den runs over stages 3 to 7 as a reciprocal multiply.
   // The reciprocal is scaled to 31 or 32 bits, so the estimate is never low and
   // at most one too high for any numerator of the coordinate range.
   localparam longint D2 = 2 * Den;
   localparam int Lg = $clog2(D2 + 1) - 1;
   localparam int Shift = 31 + Lg;
   localparam longint Recip = (longint'(1) << Shift) / D2 + 1;
   localparam logic [31:0] RecipBits = 32'(Recip);
   localparam logic [19:0] D2Bits = 20'(D2);

   // Stage 3: magnitude, since floor(a/d) = -floor((-a-1)/d) - 1 for negative a.
   logic [47:0] m3_ff [0:1];
   logic        n3_ff [0:1];
   logic        v3_ff, f3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (adv) begin
         v3_ff <= v2_ff;
      end
      if (adv) begin
         f3_ff <= f2_ff;
         for (int c = 0; c < 2; c++) begin
            m3_ff[c] <= s_ff[c][48] ? ~s_ff[c][47:0] : s_ff[c][47:0];
            n3_ff[c] <= s_ff[c][48];
         end
      end
   end

   // Stage 4: two partial products of the magnitude and the reciprocal.
   logic [55:0] ph4_ff [0:1];
   logic [55:0] pl4_ff [0:1];
   logic [47:0] m4_ff [0:1];
   logic        n4_ff [0:1];
   logic        v4_ff, f4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= v3_ff;
      end
      if (adv) begin
         f4_ff <= f3_ff;
         for (int c = 0; c < 2; c++) begin
            ph4_ff[c] <= 56'(m3_ff[c][47:24] * RecipBits);
            pl4_ff[c] <= 56'(m3_ff[c][23:0] * RecipBits);
            m4_ff[c] <= m3_ff[c];
            n4_ff[c] <= n3_ff[c];
         end
      end
   end

   // Stage 5: quotient estimate.
   logic [80:0] acc5 [0:1];
   logic [24:0] q5_ff [0:1];
   logic [47:0] m5_ff [0:1];
   logic        n5_ff [0:1];
   logic        v5_ff, f5_ff;
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         acc5[c] = {ph4_ff[c], 24'b0} + 81'(pl4_ff[c]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (adv) begin
         v5_ff <= v4_ff;
      end
      if (adv) begin
         f5_ff <= f4_ff;
         for (int c = 0; c < 2; c++) begin
            q5_ff[c] <= 25'(acc5[c] >> Shift);
            m5_ff[c] <= m4_ff[c];
            n5_ff[c] <= n4_ff[c];
         end
      end
   end

   // Stage 6: estimate times the divisor.
   logic [44:0] pr6_ff [0:1];
   logic [24:0] q6_ff [0:1];
   logic [47:0] m6_ff [0:1];
   logic        n6_ff [0:1];
   logic        v6_ff, f6_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (adv) begin
         v6_ff <= v5_ff;
      end
      if (adv) begin
         f6_ff <= f5_ff;
         for (int c = 0; c < 2; c++) begin
            pr6_ff[c] <= 45'(q5_ff[c] * D2Bits);
            q6_ff[c] <= q5_ff[c];
            m6_ff[c] <= m5_ff[c];
            n6_ff[c] <= n5_ff[c];
         end
      end
   end

   // Stage 7: drop the estimate by one when it overshoots, then restore the sign.
   logic [24:0] q7 [0:1];
   always_comb begin
      for (int c = 0; c < 2; c++) begin
         q7[c] = ({3'b0, pr6_ff[c]} > m6_ff[c]) ? q6_ff[c] - 25'd1 : q6_ff[c];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else if (adv) begin
         out_valid <= v6_ff;
      end
      if (adv) begin
         out_first <= f6_ff;
         out_x <= n6_ff[0] ? ~q7[0][CW-1:0] : q7[0][CW-1:0];
         out_y <= n6_ff[1] ? ~q7[1][CW-1:0] : q7[1][CW-1:0];
      end
   end
endmodule

// File: design/pcbd_segdist.sv
// Segment distance unit: squared distance from the query point to one segment per cycle while adv is high.
module pcbd_segdist (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic               in_last,
   input  pcbd_pkg::coord_type ox,
   input  pcbd_pkg::coord_type oy,
   input  pcbd_pkg::coord_type ax,
   input  pcbd_pkg::coord_type ay,
   input  pcbd_pkg::coord_type bx,
   input  pcbd_pkg::coord_type by,
   output logic               out_valid,
   output logic               out_last,
   output logic [50:0]        out_d2
);
   localparam int TB = pcbd_pkg::TBits;

   // Stage A: differences.
   logic signed [24:0] dx_a, dy_a, wx_a, wy_a;
   logic               va, la;
   logic signed [23:0] ax_a, ay_a, bx_a, by_a, ox_a, oy_a;
   always_ff @(posedge clock) begin
      if (reset) va <= 1'b0;
      else if (adv) va <= in_valid;
      if (adv) begin
         la <= in_last;
         dx_a <= 25'(bx) - 25'(ax);
         dy_a <= 25'(by) - 25'(ay);
         wx_a <= 25'(ox) - 25'(ax);
         wy_a <= 25'(oy) - 25'(ay);
         ax_a <= ax; ay_a <= ay; bx_a <= bx; by_a <= by; ox_a <= ox; oy_a <= oy;
      end
   end

   // Stage B: products.
   logic signed [49:0] dxx_b, dyy_b, wdx_b, wdy_b;
   logic signed [24:0] dx_b, dy_b;
   logic               vb, lb;
   logic signed [23:0] ax_b, ay_b, bx_b, by_b, ox_b, oy_b;
   always_ff @(posedge clock) begin
      if (reset) vb <= 1'b0;
      else if (adv) vb <= va;
      if (adv) begin
         lb <= la;
         dxx_b <= dx_a * dx_a; dyy_b <= dy_a * dy_a;
         wdx_b <= wx_a * dx_a; wdy_b <= wy_a * dy_a;
         dx_b <= dx_a; dy_b <= dy_a;
         ax_b <= ax_a; ay_b <= ay_a; bx_b <= bx_a; by_b <= by_a; ox_b <= ox_a; oy_b <= oy_a;
      end
   end

   // Stage C: sums and classification.
   typedef struct packed {
      logic               valid;
      logic               last;
      logic [1:0]         mode;   // 0 start point, 1 end point, 2 interior
      logic [50:0]        d2;
      logic [50:0]        rem;
      logic [TB-1:0]      t;
      logic signed [24:0] dx, dy;
      logic signed [23:0] ax, ay, bx, by, ox, oy;
   } div_type;

   localparam logic [1:0] ModeStart = 2'd0;
   localparam logic [1:0] ModeEnd = 2'd1;
   localparam logic [1:0] ModeMid = 2'd2;

   div_type c_in, c_ff;
   logic signed [51:0] d2s, nums;
   always_comb begin
      d2s = 52'(dxx_b) + 52'(dyy_b);
      nums = 52'(wdx_b) + 52'(wdy_b);
      c_in = '0;
      c_in.valid = vb; c_in.last = lb;
      c_in.d2 = d2s[50:0];
      c_in.dx = dx_b; c_in.dy = dy_b;
      c_in.ax = ax_b; c_in.ay = ay_b; c_in.bx = bx_b; c_in.by = by_b;
      c_in.ox = ox_b; c_in.oy = oy_b;
      if (d2s == 0 || nums <= 0) c_in.mode = ModeStart;
      else if (nums >= d2s) c_in.mode = ModeEnd;
      else begin
         c_in.mode = ModeMid;
         c_in.rem = nums[50:0];
      end
   end
   always_ff @(posedge clock) begin
      if (reset) c_ff.valid <= 1'b0;
      else if (adv) c_ff.valid <= c_in.valid;
      if (adv) c_ff[$bits(div_type)-2:0] <= c_in[$bits(div_type)-2:0];
   end

   // Restoring division, one quotient bit per stage.
   div_type dv [0:TB];
   assign dv[0] = c_ff;
   for (genvar s = 0; s < TB; s++) begin : g_div
      div_type nx;
      logic [51:0] r2;
      always_comb begin
         nx = dv[s];
         r2 = {dv[s].rem, 1'b0};
         nx.t = {dv[s].t[TB-2:0], 1'b0};
         if (r2 >= 52'(dv[s].d2)) begin
            nx.rem = 51'(r2 - 52'(dv[s].d2));
            nx.t[0] = 1'b1;
         end else begin
            nx.rem = r2[50:0];
         end
      end
      always_ff @(posedge clock) begin
         if (reset) dv[s+1].valid <= 1'b0;
         else if (adv) dv[s+1].valid <= nx.valid;
         if (adv) dv[s+1][$bits(div_type)-2:0] <= nx[$bits(div_type)-2:0];
      end
   end

   // Projection offsets.
   div_type p_ff;
   logic signed [42:0] mx_ff, my_ff;
   always_ff @(posedge clock) begin
      if (reset) p_ff.valid <= 1'b0;
      else if (adv) p_ff.valid <= dv[TB].valid;
      if (adv) begin
         p_ff[$bits(div_type)-2:0] <= dv[TB][$bits(div_type)-2:0];
         mx_ff <= 43'(dv[TB].dx * $signed({1'b0, dv[TB].t}));
         my_ff <= 43'(dv[TB].dy * $signed({1'b0, dv[TB].t}));
      end
   end

   // Projected point and error vector.
   logic signed [24:0] ex_ff, ey_ff;
   logic               ve, le;
   logic signed [25:0] px, py;
   logic signed [43:0] rx, ry;
   always_comb begin
      rx = 44'(mx_ff) + 44'sd32768;
      ry = 44'(my_ff) + 44'sd32768;
      unique case (p_ff.mode)
         ModeEnd: begin px = 26'(p_ff.bx); py = 26'(p_ff.by); end
         ModeMid: begin
            px = 26'(p_ff.ax) + 26'(rx >>> TB);
            py = 26'(p_ff.ay) + 26'(ry >>> TB);
         end
         default: begin px = 26'(p_ff.ax); py = 26'(p_ff.ay); end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) ve <= 1'b0;
      else if (adv) ve <= p_ff.valid;
      if (adv) begin
         le <= p_ff.last;
         ex_ff <= 25'(26'(p_ff.ox) - px);
         ey_ff <= 25'(26'(p_ff.oy) - py);
      end
   end

   // Squares.
   logic [49:0] sx_ff, sy_ff;
   logic        vs, ls;
   always_ff @(posedge clock) begin
      if (reset) vs <= 1'b0;
      else if (adv) vs <= ve;
      if (adv) begin
         ls <= le;
         sx_ff <= 50'(ex_ff * ex_ff);
         sy_ff <= 50'(ey_ff * ey_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid <= 1'b0;
      else if (adv) out_valid <= vs;
      if (adv) begin
         out_last <= ls;
         out_d2 <= 51'(sx_ff) + 51'(sy_ff);
      end
   end
endmodule

// File: design/pcbd_sqrt.sv
// Pipelined bit-by-bit square root with saturation.
module pcbd_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  logic        in_valid,
   input  logic [50:0] in_v,
   output logic        out_valid,
   output logic [pcbd_pkg::DistWidth-1:0] out_root
);
   localparam int Stages = 27;
   typedef struct packed {
      logic        valid;
      logic [52:0] v;
      logic [53:0] res;
   } root_type;

   root_type st [0:Stages];
   always_comb begin
      st[0].valid = in_valid;
      st[0].v = 53'(in_v);
      st[0].res = '0;
   end
   for (genvar k = 0; k < Stages; k++) begin : g_root
      localparam logic [53:0] Bit = 54'(1) << (52 - 2 * k);
      root_type nx;
      always_comb begin
         nx = st[k];
         if (54'(st[k].v) >= st[k].res + Bit) begin
            nx.v = 53'(54'(st[k].v) - (st[k].res + Bit));
            nx.res = (st[k].res >> 1) + Bit;
         end else begin
            nx.res = st[k].res >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) st[k+1].valid <= 1'b0;
         else if (adv) st[k+1].valid <= nx.valid;
         if (adv) begin
            st[k+1].v <= nx.v;
            st[k+1].res <= nx.res;
         end
      end
   end

   assign out_valid = st[Stages].valid;
   assign out_root = (st[Stages].res > 54'(24'hFFFFFF)) ? 24'hFFFFFF
                     : st[Stages].res[pcbd_pkg::DistWidth-1:0];
endmodule

// File: design/pcbd_checker.sv
// Port checker for the Bezier distance block, bound to the top level.
module pcbd_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [23:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed under stall");
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a word was taken");
endmodule

bind point_to_cubic_bezier_distance pcbd_checker u_pcbd_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata[23:0])
);
